// ===== sv/sct_pkg.sv =====
// Shared types, codes and defaults for the sorted coordinate table.
package sct_pkg;

  localparam int ENTRIES_DEF    = 256;
  localparam int VALUE_BITS_DEF = 8;
  localparam int KEY_BITS       = 32;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_DUP  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;
  localparam logic [1:0] STAT_MISS = 2'd3;

  typedef struct packed {
    logic signed [KEY_BITS-1:0] x;
    logic signed [KEY_BITS-1:0] y;
    logic signed [KEY_BITS-1:0] z;
  } sct_key_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } sct_cmp_t;

endpackage

// ===== sv/sct_if.sv =====
// Request and response channel interfaces of the sorted coordinate table.
interface sct_req_if import sct_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic signed [KEY_BITS-1:0] key_x;
  logic signed [KEY_BITS-1:0] key_y;
  logic signed [KEY_BITS-1:0] key_z;
  logic [7:0]                 entry_value;

  modport source (output valid, kind, key_x, key_y, key_z, entry_value, input ready);
  modport sink   (input valid, kind, key_x, key_y, key_z, entry_value, output ready);
endinterface

interface sct_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] found_value;
  logic [7:0] found_index;
  logic [8:0] entry_count;

  modport source (output valid, status, found_value, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_value, found_index, entry_count, output ready);
endinterface

// ===== sv/sct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/sct_cmp.sv =====
// Signed x, y, z ordering compare of a stored record against the search key.
module sct_cmp import sct_pkg::*; (
  input  sct_key_t rec,
  input  sct_key_t key,
  output sct_cmp_t res
);

  logic x_lt, y_lt, z_lt, x_eq, y_eq, z_eq;

  always_comb begin
    x_lt = $signed(rec.x) < $signed(key.x);
    y_lt = $signed(rec.y) < $signed(key.y);
    z_lt = $signed(rec.z) < $signed(key.z);
    x_eq = rec.x == key.x;
    y_eq = rec.y == key.y;
    z_eq = rec.z == key.z;
    res.lt = x_lt || (x_eq && y_lt) || (x_eq && y_eq && z_lt);
    res.eq = x_eq && y_eq && z_eq;
  end

endmodule

// ===== sv/sorted_coordinate_table_unit.sv =====
// Sorted coordinate table: sequencer, record RAM and shared key compare.
//
// Usage: one request beat on req carries kind (insert, remove, lookup),
// a signed x/y/z key and a value; one response beat on rsp returns status,
// found_value, found_index and entry_count. req.ready is high only while
// the sequencer is idle; one request is worked at a time.
// Each binary-search probe reads the RAM, then compares the record
// against the key in the shared compare unit.
// Insert and remove then move every later record by one place, one RAM
// word per cycle through the single read and write port, then drain the
// last write; an insert then writes its new record into the gap.
// The response sits in an output register: a new request is taken while
// the previous response waits, and a finished result holds in the
// sequencer until the output register is free when rsp stalls.
// Reset empties the table at once (count to zero); the RAM is not cleared,
// as only entries below the count are ever read.
module sorted_coordinate_table_unit import sct_pkg::*; #(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  sct_req_if.sink   req,
  sct_rsp_if.source rsp
);

  localparam int AW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int KW   = 3 * KEY_BITS;
  localparam int WORD = KW + VALUE_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_PROBE, S_DECIDE, S_SHIFT, S_PUT, S_FIN
  } state_t;

  state_t                state;
  logic [1:0]            op_kind;
  sct_key_t              op_key;
  logic [VALUE_BITS-1:0] op_val;
  logic [CW-1:0]         count;
  logic [CW-1:0]         lo, hi;
  logic [AW-1:0]         mid_q;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_val;
  logic [AW-1:0]         ptr, end_addr, last;
  logic                  pend, issued;
  logic [1:0]            res_status;
  logic [7:0]            res_val;
  logic [CW-1:0]         res_idx;

  logic                  out_valid;
  logic [1:0]            out_status;
  logic [7:0]            out_value;
  logic [7:0]            out_index;
  logic [8:0]            out_count;

  logic [CW-1:0]         mid_full, count_m1, hi_p1;
  logic [AW-1:0]         mid;
  logic                  op_ins, load_out;
  logic                  we;
  logic [AW-1:0]         waddr, raddr;
  logic [WORD-1:0]       wdata, rdata;
  sct_key_t              rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  sct_cmp_t              cmp;
  logic [31:0]           val_w, idx_w, cnt_w, in_val_w;

  always_comb begin
    mid_full = lo + ((hi - lo) >> 1);
    mid      = mid_full[AW-1:0];
    count_m1 = count - 1'b1;
    hi_p1    = hi + 1'b1;
    op_ins   = op_kind == KIND_INSERT;
    load_out = (state == S_FIN) && (!out_valid || rsp.ready);
    rd_key   = sct_key_t'(rdata[WORD-1 -: KW]);
    rd_val   = rdata[VALUE_BITS-1:0];
    val_w    = 32'(hit_val);
    idx_w    = 32'(res_idx);
    cnt_w    = 32'(count);
    in_val_w = 32'(req.entry_value);
    raddr    = (state == S_SRCH) ? mid : ptr;
    we       = 1'b0;
    waddr    = last;
    wdata    = rdata;
    if (state == S_SHIFT && pend) begin
      we    = 1'b1;
      waddr = op_ins ? last + 1'b1 : last - 1'b1;
    end else if (state == S_PUT) begin
      we    = 1'b1;
      waddr = hi[AW-1:0];
      wdata = {op_key, op_val};
    end
  end

  sct_ram #(
    .WIDTH (WORD),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  sct_cmp u_cmp (
    .rec (rd_key),
    .key (op_key),
    .res (cmp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      issued    <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && !load_out) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            op_kind <= req.kind;
            op_key  <= '{x: req.key_x, y: req.key_y, z: req.key_z};
            op_val  <= in_val_w[VALUE_BITS-1:0];
            lo      <= '0;
            hi      <= count;
            hit     <= 1'b0;
            state   <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo < hi) begin
            mid_q <= mid;
            state <= S_PROBE;
          end else begin
            state <= S_DECIDE;
          end
        end
        S_PROBE: begin
          if (cmp.lt) begin
            lo <= CW'(mid_q) + 1'b1;
          end else begin
            hi      <= CW'(mid_q);
            hit     <= cmp.eq;
            hit_val <= rd_val;
          end
          state <= S_SRCH;
        end
        S_DECIDE: begin
          pend   <= 1'b0;
          issued <= 1'b0;
          if (op_kind == KIND_INSERT) begin
            res_val <= '0;
            if (hit) begin
              res_status <= STAT_DUP;
              res_idx    <= hi;
              state      <= S_FIN;
            end else if (count == CW'(ENTRIES)) begin
              res_status <= STAT_FULL;
              res_idx    <= '0;
              state      <= S_FIN;
            end else if (hi < count) begin
              res_status <= STAT_DONE;
              res_idx    <= hi;
              ptr        <= count_m1[AW-1:0];
              end_addr   <= hi[AW-1:0];
              state      <= S_SHIFT;
            end else begin
              res_status <= STAT_DONE;
              res_idx    <= hi;
              state      <= S_PUT;
            end
          end else if (op_kind == KIND_REMOVE) begin
            res_val <= '0;
            if (!hit) begin
              res_status <= STAT_MISS;
              res_idx    <= '0;
              state      <= S_FIN;
            end else begin
              res_status <= STAT_DONE;
              res_idx    <= hi;
              count      <= count_m1;
              if (hi_p1 < count) begin
                ptr      <= hi_p1[AW-1:0];
                end_addr <= count_m1[AW-1:0];
                state    <= S_SHIFT;
              end else begin
                state <= S_FIN;
              end
            end
          end else begin
            state <= S_FIN;
            if (!hit) begin
              res_status <= STAT_MISS;
              res_idx    <= '0;
              res_val    <= '0;
            end else begin
              res_status <= STAT_DONE;
              res_idx    <= hi;
              res_val    <= val_w[7:0];
            end
          end
        end
        S_SHIFT: begin
          if (!issued) begin
            last <= ptr;
            pend <= 1'b1;
            if (ptr == end_addr) begin
              issued <= 1'b1;
            end else begin
              ptr <= op_ins ? ptr - 1'b1 : ptr + 1'b1;
            end
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              state <= op_ins ? S_PUT : S_FIN;
            end
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_value  <= res_val;
            out_index  <= idx_w[7:0];
            out_count  <= cnt_w[8:0];
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = state == S_IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found_value = out_value;
  assign rsp.found_index = out_index;
  assign rsp.entry_count = out_count;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(ENTRIES))
    else $error("record count above table size");

  a_search_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SRCH) |-> (lo <= hi))
    else $error("binary search bounds crossed");

  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !we)
    else $error("RAM written while idle");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT) |=> (count == $past(count) + 1'b1) && (state == S_FIN))
    else $error("insert did not grow the table");
`endif

endmodule
